// ===== src/mccp_pkg.sv =====
// mccp_pkg: shared types and constants for the motion correlation candidate picker
// no dependencies
`timescale 1ns / 1ps
package mccp_pkg;

   localparam int ScoreW = 7;
   localparam int WinW = 8;
   localparam int HashW = 24;
   localparam int LevelW = 8;
   localparam int RangeW = 17;
   localparam logic signed [ScoreW-1:0] ScoreLo = -7'sd32;
   localparam logic signed [ScoreW-1:0] ScoreHi = 7'sd32;
   localparam logic [WinW-1:0] WinMax = 8'hFF;

   typedef enum logic [1:0] {
      OP_FEED   = 2'd0,
      OP_RETIRE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_SCORE_FLOOR  = 3'd0,
      CSR_WINDOW_FLOOR = 3'd1,
      CSR_LEAD_FLOOR   = 3'd2,
      CSR_LEVEL_FLOOR  = 3'd3,
      CSR_RANGE_FLOOR  = 3'd4,
      CSR_CLUSTER      = 3'd5
   } csr_type;

   // one classified command handed from front to back
   typedef struct packed {
      op_type                    op;
      logic                      active;   // feed that passes role and range tests
      logic [HashW-1:0]          hash;
      logic signed [LevelW-1:0]  level;
      logic signed [RangeW-1:0]  range;
   } cmd_type;

   typedef struct packed {
      logic signed [ScoreW-1:0] score_floor;
      logic [WinW-1:0]          window_floor;
      logic [6:0]               lead_floor;
      logic [7:0]               level_floor;
      logic [15:0]              range_floor;
      logic [7:0]               cluster_level;
   } cfg_type;

   // packed with pick_valid in the lowest bit, as on the response bus
   typedef struct packed {
      logic [15:0]              eviction_count;
      logic [6:0]               used_count;
      logic [7:0]               runner_gap;
      logic signed [ScoreW-1:0] rival_score;
      logic [WinW-1:0]          top_windows;
      logic signed [ScoreW-1:0] top_score;
      logic [HashW-1:0]         best_hash;
      logic                     have_any;
      logic                     pick_valid;
   } rsp_type;

endpackage

// ===== src/mccp_front.sv =====
// mccp_front: accepts request transfers, classifies them, and keeps a two-entry queue
// depends on mccp_pkg
`timescale 1ns / 1ps
module mccp_front import mccp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  op_type  in_op,
   input  logic [HashW-1:0] in_hash,
   input  logic signed [LevelW-1:0] in_level,
   input  logic signed [RangeW-1:0] in_range,
   input  logic    in_role,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd
);
   cmd_type q_ff [2];
   cmd_type q_in0, q_in1;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;
   cmd_type c;

   // classify the incoming item
   always_comb begin
      c.op     = in_op;
      c.active = (in_op == OP_FEED) && in_role && !in_range[RangeW-1];
      c.hash   = in_hash;
      c.level  = in_level;
      c.range  = in_range;
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign push      = in_valid && in_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[0];

   // queue update, head at entry zero
   always_comb begin
      q_in0  = q_ff[0];
      q_in1  = q_ff[1];
      cnt_in = cnt_ff;
      if (pop) begin
         q_in0 = q_ff[1];
      end
      if (push) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)) q_in0 = c;
         else q_in1 = c;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in0;
      q_ff[1] <= q_in1;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== src/mccp_back.sv =====
// mccp_back: slot table and sequencer that applies one command and scans for the pick
// depends on mccp_pkg
`timescale 1ns / 1ps
module mccp_back import mccp_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   input  cfg_type cfg,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_rsp
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FIND   = 6'b000010,
      ST_APPLY  = 6'b000100,
      ST_BEST   = 6'b001000,
      ST_RUNNER = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   cmd_type cmd_ff;
   logic [IW-1:0] i_ff;
   logic [SLOTS-1:0] used_ff;
   logic [HashW-1:0] hash_ff [SLOTS];
   logic signed [ScoreW-1:0] score_ff [SLOTS];
   logic [WinW-1:0] win_ff [SLOTS];
   logic [SLOTS-1:0] prev_ff;
   logic signed [LevelW-1:0] lvl_ff [SLOTS];
   logic signed [RangeW-1:0] rng_ff [SLOTS];
   logic [15:0] evict_ff;
   // find scan results
   logic hit_ff, free_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, vic_ff;
   // best and runner scan
   logic have_ff;
   logic [IW-1:0] best_ff;
   logic [CW-1:0] n_ff;
   logic signed [ScoreW-1:0] run_ff;
   logic [7:0] gap_ff;
   logic pick_ok;
   rsp_type rsp_ff;
   logic out_ff;

   logic last;
   assign last = (i_ff == IW'(SLOTS - 1));
   assign cmd_ready = st_ff == ST_IDLE;
   assign out_valid = out_ff;
   assign out_rsp = rsp_ff;

   // per-slot feed arithmetic on the target slot, and the rival test for the runner-up scan
   logic [IW-1:0] tgt;
   logic signed [LevelW:0] dl;
   logic signed [RangeW:0] dr;
   logic [LevelW:0] adl;
   logic [RangeW:0] adr;
   logic scored, opp;
   logic signed [ScoreW-1:0] sc_old, sc_new;
   logic signed [LevelW:0] d_lvl;
   logic [LevelW:0] ad_lvl;
   logic rival;

   always_comb begin
      tgt = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : vic_ff);
      dl  = {cmd_ff.level[LevelW-1], cmd_ff.level} - {lvl_ff[tgt][LevelW-1], lvl_ff[tgt]};
      dr  = {cmd_ff.range[RangeW-1], cmd_ff.range} - {rng_ff[tgt][RangeW-1], rng_ff[tgt]};
      adl = dl[LevelW] ? (LevelW+1)'(-dl) : dl;
      adr = dr[RangeW] ? (RangeW+1)'(-dr) : dr;
      scored = (adl >= {1'b0, cfg.level_floor}) && (adr >= (RangeW+1)'(cfg.range_floor));
      opp = (dl > 0 && dr < 0) || (dl < 0 && dr > 0);
      sc_old = hit_ff ? score_ff[tgt] : '0;
      if (opp) sc_new = (sc_old < ScoreHi) ? sc_old + 7'sd1 : sc_old;
      else sc_new = (sc_old < ScoreLo + 7'sd2) ? ScoreLo : sc_old - 7'sd2;
      d_lvl = {lvl_ff[i_ff][LevelW-1], lvl_ff[i_ff]} - {lvl_ff[best_ff][LevelW-1],
              lvl_ff[best_ff]};
      ad_lvl = d_lvl[LevelW] ? (LevelW+1)'(-d_lvl) : d_lvl;
      rival = used_ff[i_ff] && (i_ff != best_ff) &&
              !((score_ff[i_ff] >= cfg.score_floor) && (ad_lvl <= {1'b0, cfg.cluster_level}));
   end

   // sequencer
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:   if (cmd_valid) st_in = (cmd.op == OP_FEED || cmd.op == OP_RETIRE) ?
                                     ST_FIND : ST_APPLY;
         ST_FIND:   if (last) st_in = ST_APPLY;
         ST_APPLY:  st_in = ST_BEST;
         ST_BEST:   if (last) st_in = ST_RUNNER;
         ST_RUNNER: if (last) st_in = ST_DONE;
         ST_DONE:   if (!out_ff || out_ready) st_in = ST_IDLE;
         default:   st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         out_ff   <= 1'b0;
         used_ff  <= '0;
         prev_ff  <= '0;
         evict_ff <= '0;
         i_ff     <= '0;
         for (int k = 0; k < SLOTS; k++) begin
            hash_ff[k] <= '0; score_ff[k] <= '0; win_ff[k] <= '0;
            lvl_ff[k] <= '0; rng_ff[k] <= '0;
         end
      end else begin
         st_ff <= st_in;
         if (out_ff && out_ready && st_ff != ST_DONE) out_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: begin
               cmd_ff <= cmd;
               i_ff <= '0;
               hit_ff <= 1'b0; free_ff <= 1'b0; vic_ff <= '0;
            end
            ST_FIND: begin
               // lookup, first free slot and eviction victim in one pass
               if (used_ff[i_ff] && hash_ff[i_ff] == cmd_ff.hash && !hit_ff) begin
                  hit_ff <= 1'b1; hit_idx_ff <= i_ff;
               end
               if (!used_ff[i_ff] && !free_ff) begin
                  free_ff <= 1'b1; free_idx_ff <= i_ff;
               end
               if (i_ff != '0 && (score_ff[i_ff] < score_ff[vic_ff] ||
                   (score_ff[i_ff] == score_ff[vic_ff] && win_ff[i_ff] > win_ff[vic_ff])))
                  vic_ff <= i_ff;
               i_ff <= last ? '0 : i_ff + 1'b1;
            end
            ST_APPLY: begin
               i_ff <= '0;
               if (cmd_ff.op == OP_CLEAR) begin
                  used_ff <= '0; prev_ff <= '0; evict_ff <= '0;
                  for (int k = 0; k < SLOTS; k++) begin
                     hash_ff[k] <= '0; score_ff[k] <= '0; win_ff[k] <= '0;
                     lvl_ff[k] <= '0; rng_ff[k] <= '0;
                  end
               end else if (cmd_ff.op == OP_RETIRE && hit_ff) begin
                  used_ff[hit_idx_ff] <= 1'b0; prev_ff[hit_idx_ff] <= 1'b0;
                  hash_ff[hit_idx_ff] <= '0; score_ff[hit_idx_ff] <= '0;
                  win_ff[hit_idx_ff] <= '0; lvl_ff[hit_idx_ff] <= '0;
                  rng_ff[hit_idx_ff] <= '0;
               end else if (cmd_ff.op == OP_FEED && cmd_ff.active) begin
                  if (!hit_ff && !free_ff) evict_ff <= evict_ff + 16'd1;
                  used_ff[tgt] <= 1'b1;
                  hash_ff[tgt] <= cmd_ff.hash;
                  prev_ff[tgt] <= 1'b1;
                  lvl_ff[tgt]  <= cmd_ff.level;
                  rng_ff[tgt]  <= cmd_ff.range;
                  if (!hit_ff) win_ff[tgt] <= 8'd1;
                  else if (win_ff[tgt] < WinMax) win_ff[tgt] <= win_ff[tgt] + 8'd1;
                  if (hit_ff && prev_ff[tgt] && scored) score_ff[tgt] <= sc_new;
                  else if (!hit_ff) score_ff[tgt] <= '0;
               end
               have_ff <= 1'b0; best_ff <= '0; n_ff <= '0;
            end
            ST_BEST: begin
               if (used_ff[i_ff]) begin
                  n_ff <= n_ff + 1'b1;
                  if (!have_ff || score_ff[i_ff] > score_ff[best_ff]) best_ff <= i_ff;
                  have_ff <= 1'b1;
               end
               i_ff <= last ? '0 : i_ff + 1'b1;
               run_ff <= ScoreLo; gap_ff <= '0;
            end
            ST_RUNNER: begin
               if (have_ff && rival && score_ff[i_ff] > run_ff) begin
                  run_ff <= score_ff[i_ff];
                  gap_ff <= ad_lvl[7:0];
               end
               i_ff <= last ? '0 : i_ff + 1'b1;
            end
            ST_DONE: begin
               if (!out_ff || out_ready) begin
                  out_ff <= 1'b1;
                  rsp_ff.have_any       <= have_ff;
                  rsp_ff.best_hash      <= have_ff ? hash_ff[best_ff] : '0;
                  rsp_ff.top_score      <= have_ff ? score_ff[best_ff] : '0;
                  rsp_ff.top_windows    <= have_ff ? win_ff[best_ff] : '0;
                  rsp_ff.rival_score    <= run_ff;
                  rsp_ff.runner_gap     <= gap_ff;
                  rsp_ff.used_count     <= 7'(n_ff);
                  rsp_ff.eviction_count <= evict_ff;
                  rsp_ff.pick_valid     <= pick_ok;
               end
            end
            default: ;
         endcase
      end
   end

   // pick test on the finished scan
   always_comb begin
      pick_ok = have_ff && (score_ff[best_ff] >= cfg.score_floor) &&
                (win_ff[best_ff] >= cfg.window_floor) &&
                (($signed({score_ff[best_ff][ScoreW-1], score_ff[best_ff]}) -
                  $signed({run_ff[ScoreW-1], run_ff})) >= $signed({1'b0, cfg.lead_floor}));
   end
endmodule

// ===== src/motion_correlation_candidate_picker.sv =====
// channel | direction | payload
// req     | in        | op, label_hash, mean_level_dbm, range_now_mm, role_outside
// rsp     | out       | pick_valid .. eviction_count, one per request
// csr     | in        | register index and write data
// When the back end is idle, a feed or retire goes from request transfer to response
// valid through a lookup pass, an apply step, the best and runner-up passes and an
// output load. Clear and unused ops skip the lookup pass. A two-entry queue takes
// requests while the back end works. Reset is synchronous and clears table, counter
// and registers to their defaults. A stalled response holds the back end only.
// depends on mccp_pkg, mccp_front, mccp_back
`timescale 1ns / 1ps
module motion_correlation_candidate_picker import mccp_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[1:0], label_hash[25:2], mean_level_dbm[33:26], range_now_mm[50:34],
   // role_outside[51], zero fill to 56
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pick_valid[0], have_any[1], best_hash[25:2], top score[32:26],
   // top windows[40:33], rival score[47:41], runner gap[55:48],
   // used_count[62:56], eviction_count[78:63], zero fill to 80
   output logic [79:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   cfg_type cfg_ff;
   logic cmd_valid, cmd_ready;
   cmd_type cmd;
   rsp_type r;

   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{score_floor: 7'sd3, window_floor: 8'd3, lead_floor: 7'd2,
                     level_floor: 8'd3, range_floor: 16'd300, cluster_level: 8'd6};
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCORE_FLOOR:  cfg_ff.score_floor   <= csr_data[6:0];
            CSR_WINDOW_FLOOR: cfg_ff.window_floor  <= csr_data[7:0];
            CSR_LEAD_FLOOR:   cfg_ff.lead_floor    <= csr_data[6:0];
            CSR_LEVEL_FLOOR:  cfg_ff.level_floor   <= csr_data[7:0];
            CSR_RANGE_FLOOR:  cfg_ff.range_floor   <= csr_data;
            CSR_CLUSTER:      cfg_ff.cluster_level <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   mccp_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_op(op_type'(req_tdata[1:0])), .in_hash(req_tdata[25:2]),
      .in_level(req_tdata[33:26]), .in_range(req_tdata[50:34]),
      .in_role(req_tdata[51]),
      .cmd_valid, .cmd_ready, .cmd
   );

   mccp_back #(.SLOTS(SLOTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd, .cfg(cfg_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(r)
   );

   assign rsp_tdata = {1'b0, r.eviction_count, r.used_count, r.runner_gap, r.rival_score,
                       r.top_windows, r.top_score, r.best_hash, r.have_any, r.pick_valid};
endmodule

// ===== src/mccp_checker.sv =====
// mccp_checker: port-level checks on the picker, bound to the top level
// depends on motion_correlation_candidate_picker ports
`timescale 1ns / 1ps
module mccp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);
   // a waiting response holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("rsp payload moved");
   // no response directly after reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp after reset");
   // have_any agrees with used count
   a_any: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1] == (rsp_tdata[62:56] != 7'd0))) else $error("have_any");
   // valid pick implies a best label
   a_pick: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1]) else $error("pick without best");
endmodule

bind motion_correlation_candidate_picker mccp_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

// ===== test/motion_correlation_candidate_picker_tb.sv =====
// motion_correlation_candidate_picker_tb: self-checking bench for the candidate picker
// predicts each response from its own slot table model; depends on mccp_pkg and the rtl
`timescale 1ns / 1ps
module motion_correlation_candidate_picker_tb;
   import mccp_pkg::*;

   localparam int NSLOT = 8;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   motion_correlation_candidate_picker dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // predictor copy of registers and table
   int          cf_score_floor, cf_window_floor, cf_lead_floor;
   int          cf_level_floor, cf_range_floor, cf_cluster;
   bit          t_used [NSLOT];
   logic [23:0] t_hash [NSLOT];
   int          t_score [NSLOT];
   int          t_win [NSLOT];
   bit          t_prev [NSLOT];
   int          t_level [NSLOT];
   int          t_range [NSLOT];
   logic [15:0] t_evict;

   logic [55:0] pending_reqs [$];
   rsp_type     expected_picks [$];
   int          errors = 0;
   int          cycles = 0;
   bit          quiet = 1'b0;   // no idling stretch
   bit          hold_req = 1'b0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   function automatic void wipe_slot(int i);
      t_used[i] = 0; t_hash[i] = '0; t_score[i] = 0; t_win[i] = 0;
      t_prev[i] = 0; t_level[i] = 0; t_range[i] = 0;
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < NSLOT; i++) wipe_slot(i);
      t_evict = '0;
   endfunction

   function automatic int slot_for(logic [23:0] h);
      int pick;
      pick = -1;
      for (int i = 0; i < NSLOT; i++)
         if (t_used[i] && t_hash[i] == h) return i;
      for (int i = 0; i < NSLOT; i++) begin
         if (!t_used[i]) begin
            pick = i;
            break;
         end
         if (pick < 0 || t_score[i] < t_score[pick] ||
             (t_score[i] == t_score[pick] && t_win[i] > t_win[pick])) pick = i;
      end
      if (t_used[pick]) t_evict++;
      wipe_slot(pick);
      t_used[pick] = 1;
      t_hash[pick] = h;
      return pick;
   endfunction

   function automatic void score_sighting(logic [23:0] h, int lv, int rg);
      int i, dl, dr;
      i = slot_for(h);
      if (t_win[i] < 255) t_win[i]++;
      if (!t_prev[i]) begin
         t_prev[i] = 1; t_level[i] = lv; t_range[i] = rg;
         return;
      end
      dl = lv - t_level[i];
      dr = rg - t_range[i];
      t_level[i] = lv; t_range[i] = rg;
      if ((dl < 0 ? -dl : dl) < cf_level_floor || (dr < 0 ? -dr : dr) < cf_range_floor)
         return;
      if ((dl > 0 && dr < 0) || (dl < 0 && dr > 0)) begin
         if (t_score[i] < 32) t_score[i]++;
      end else begin
         t_score[i] = (t_score[i] - 2 < -32) ? -32 : t_score[i] - 2;
      end
   endfunction

   function automatic rsp_type pick_candidate(logic [55:0] d);
      op_type      op;
      logic [23:0] h;
      int          lv, rg, best, n, runner, gap, dd;
      rsp_type     r;
      op = op_type'(d[1:0]);
      h = d[25:2];
      lv = $signed(d[33:26]);
      rg = $signed(d[50:34]);
      best = -1; n = 0; runner = -32; gap = 0;
      case (op)
         OP_FEED: if (rg >= 0 && d[51]) score_sighting(h, lv, rg);
         OP_RETIRE: begin
            for (int i = 0; i < NSLOT; i++)
               if (t_used[i] && t_hash[i] == h) begin
                  wipe_slot(i);
                  break;
               end
         end
         OP_CLEAR: wipe_table();
         default: ;
      endcase
      for (int i = 0; i < NSLOT; i++)
         if (t_used[i]) begin
            n++;
            if (best < 0 || t_score[i] > t_score[best]) best = i;
         end
      r = '0;
      if (best >= 0) begin
         for (int i = 0; i < NSLOT; i++) begin
            if (!t_used[i] || i == best) continue;
            dd = t_level[i] - t_level[best];
            if (dd < 0) dd = -dd;
            if (t_score[i] >= cf_score_floor && dd <= cf_cluster) continue;
            if (t_score[i] > runner) begin
               runner = t_score[i];
               gap = dd;
            end
         end
         r.pick_valid = t_score[best] >= cf_score_floor && t_win[best] >= cf_window_floor &&
                        t_score[best] - runner >= cf_lead_floor;
         r.have_any = 1'b1;
         r.best_hash = t_hash[best];
         r.top_score = 7'(t_score[best]);
         r.top_windows = 8'(t_win[best]);
      end
      r.rival_score = 7'(runner);
      r.runner_gap = 8'(gap);
      r.used_count = 7'(n);
      r.eviction_count = t_evict;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && !hold_req &&
                (quiet || $urandom_range(99) >= 17)) begin
               req_tdata <= pending_reqs[0];
               expected_picks.push_back(pick_candidate(pending_reqs.pop_front()));
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= quiet || $urandom_range(99) >= 17;
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[78:0];
         if (rsp_tdata[79]) report("fill", 32'(rsp_tdata[79]), 32'd0);
         if (expected_picks.size() == 0) begin
            report("unexpected transfer", 32'(got.best_hash), 32'd0);
         end else begin
            want = expected_picks.pop_front();
            if (got.pick_valid != want.pick_valid)
               report("pick_valid", 32'(got.pick_valid), 32'(want.pick_valid));
            if (got.have_any != want.have_any)
               report("have_any", 32'(got.have_any), 32'(want.have_any));
            if (got.best_hash != want.best_hash)
               report("best_hash", 32'(got.best_hash), 32'(want.best_hash));
            if (got.top_score != want.top_score)
               report("top_score", 32'(got.top_score), 32'(want.top_score));
            if (got.top_windows != want.top_windows)
               report("top_windows", 32'(got.top_windows), 32'(want.top_windows));
            if (got.rival_score != want.rival_score)
               report("rival_score", 32'(got.rival_score), 32'(want.rival_score));
            if (got.runner_gap != want.runner_gap)
               report("runner_gap", 32'(got.runner_gap), 32'(want.runner_gap));
            if (got.used_count != want.used_count)
               report("used_count", 32'(got.used_count), 32'(want.used_count));
            if (got.eviction_count != want.eviction_count)
               report("eviction_count", 32'(got.eviction_count), 32'(want.eviction_count));
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", expected_picks.size());
         $display("[motion_correlation_candidate_picker] ERROR");
         $finish;
      end
   end

   function automatic logic [55:0] pack_req(op_type op, logic [23:0] h, logic [7:0] lv,
                                            logic [16:0] rg, logic role);
      return {4'b0, role, rg, lv, h, op};
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_picks.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(csr_type idx, logic [15:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SCORE_FLOOR:  cf_score_floor = $signed(val[6:0]);
         CSR_WINDOW_FLOOR: cf_window_floor = val[7:0];
         CSR_LEAD_FLOOR:   cf_lead_floor = val[6:0];
         CSR_LEVEL_FLOOR:  cf_level_floor = val[7:0];
         CSR_RANGE_FLOOR:  cf_range_floor = val;
         CSR_CLUSTER:      cf_cluster = val[7:0];
         default: ;
      endcase
   endtask

   // tracks of ten labels moving in correlated or random ways, mixed with retires, random requests and ignored feeds
   task automatic queue_tracks(int count);
      logic [23:0] labels [10];
      int          lv [10], rg [10];
      int          k, step;
      for (int i = 0; i < 10; i++) begin
         labels[i] = (i < 5) ? 24'(24'h100 + i) : 24'($urandom);
         lv[i] = $urandom_range(100) - 90;
         rg[i] = $urandom_range(60000);
      end
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(9);
         case ($urandom_range(19))
            0: pending_reqs.push_back(pack_req(OP_RETIRE, labels[k], 8'd0, 17'd0, 1'b0));
            1: pending_reqs.push_back(pack_req(op_type'($urandom_range(3)), 24'($urandom),
                                               8'($urandom), 17'($urandom), 1'($urandom)));
            2: pending_reqs.push_back(pack_req(OP_FEED, labels[k], 8'(lv[k]),
                                               17'(-$urandom_range(65536)), 1'b1));
            3: pending_reqs.push_back(pack_req(OP_FEED, labels[k], 8'(lv[k]), 17'(rg[k]),
                                               1'b0));
            default: begin
               step = $urandom_range(1, 8);
               if (k < 3 || $urandom_range(1)) begin
                  lv[k] += ($urandom_range(1) ? step : -step);
                  rg[k] += (step * ($urandom_range(1) ? -150 : 150));
               end else begin
                  lv[k] += step;
                  rg[k] += step * 150;
               end
               if (lv[k] > 127) lv[k] = 127;
               if (lv[k] < -128) lv[k] = -128;
               if (rg[k] < 0) rg[k] = 0;
               if (rg[k] > 65535) rg[k] = 65535;
               pending_reqs.push_back(pack_req(OP_FEED, labels[k], 8'(lv[k]), 17'(rg[k]),
                                               1'b1));
            end
         endcase
      end
   endtask

   initial begin
      cf_score_floor = 3; cf_window_floor = 3; cf_lead_floor = 2;
      cf_level_floor = 3; cf_range_floor = 300; cf_cluster = 6;
      wipe_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, every op, ignored feeds, eviction, retire
      pending_reqs.push_back(pack_req(OP_FEED, 24'hFFFFFF, 8'h7F, 17'h0FFFF, 1'b1));
      pending_reqs.push_back(pack_req(OP_FEED, 24'hFFFFFF, 8'h80, 17'h00000, 1'b1));
      pending_reqs.push_back(pack_req(OP_FEED, 24'h000000, 8'h80, 17'h00000, 1'b1));
      pending_reqs.push_back(pack_req(OP_FEED, 24'h000000, 8'h7F, 17'h0FFFF, 1'b1));
      pending_reqs.push_back(pack_req(OP_FEED, 24'h000001, 8'h00, 17'h10000, 1'b1));
      pending_reqs.push_back(pack_req(OP_FEED, 24'h000001, 8'h00, 17'h00100, 1'b0));
      for (int i = 0; i < 9; i++)
         pending_reqs.push_back(pack_req(OP_FEED, 24'(24'h20 + i), 8'(i), 17'd500, 1'b1));
      pending_reqs.push_back(pack_req(OP_FEED, 24'h20, 8'd0, 17'd500, 1'b1));
      pending_reqs.push_back(pack_req(OP_RETIRE, 24'h21, 8'd0, 17'd0, 1'b0));
      pending_reqs.push_back(pack_req(OP_RETIRE, 24'hABCDEF, 8'd0, 17'd0, 1'b0));
      pending_reqs.push_back(pack_req(OP_NONE, 24'h22, 8'h55, 17'h1AAAA, 1'b1));
      pending_reqs.push_back(pack_req(OP_CLEAR, 24'h0, 8'd0, 17'd0, 1'b0));
      drain();

      // register sweeps: reset values, extremes, zero floors
      queue_tracks(150);
      drain();
      write_reg(CSR_SCORE_FLOOR, 16'h0060);      // -32
      write_reg(CSR_WINDOW_FLOOR, 16'd0);
      write_reg(CSR_LEAD_FLOOR, 16'd0);
      write_reg(CSR_LEVEL_FLOOR, 16'd0);
      write_reg(CSR_RANGE_FLOOR, 16'd0);
      write_reg(CSR_CLUSTER, 16'd0);
      queue_tracks(150);
      drain();
      write_reg(CSR_SCORE_FLOOR, 16'd32);
      write_reg(CSR_WINDOW_FLOOR, 16'd255);
      write_reg(CSR_LEAD_FLOOR, 16'd64);
      write_reg(CSR_LEVEL_FLOOR, 16'd255);
      write_reg(CSR_RANGE_FLOOR, 16'hFFFF);
      write_reg(CSR_CLUSTER, 16'd255);
      queue_tracks(100);
      drain();
      write_reg(CSR_SCORE_FLOOR, 16'd1);
      write_reg(CSR_WINDOW_FLOOR, 16'd2);
      write_reg(CSR_LEAD_FLOOR, 16'd1);
      write_reg(CSR_LEVEL_FLOOR, 16'd2);
      write_reg(CSR_RANGE_FLOOR, 16'd200);
      write_reg(CSR_CLUSTER, 16'd4);
      quiet = 1'b1;
      queue_tracks(200);
      drain();
      quiet = 1'b0;
      hold_req = 1'b1;
      queue_tracks(100);
      hold_req = 1'b0;
      drain();
      write_reg(CSR_SCORE_FLOOR, 16'($urandom));
      write_reg(CSR_CLUSTER, 16'($urandom));
      queue_tracks(130);
      drain();

      if (errors == 0) begin
         $display("[motion_correlation_candidate_picker] OK");
      end else begin
         $display("[motion_correlation_candidate_picker] ERROR");
      end
      $finish;
   end
endmodule
